>>> rtl/buffer_slot_pool_allocator_unit_assert.svh
// Assertion macros used by the slot pool allocator RTL.
// Expects clk and rst (synchronous, active high) in the using module.
`ifndef BUFFER_SLOT_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define BUFFER_SLOT_POOL_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BSPA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSPA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bspa_pkg.sv
// Shared types and constants for the slot pool allocator.
// No dependencies.
package bspa_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int CHUNK_MAX     = 64;
  localparam int SLOT_W        = 6;
  localparam int AMT_W         = 7;
  localparam int CNT_OUT_W     = 7;
  localparam int STATUS_W      = 2;
  localparam int REQ_W         = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_ADD     = 2'd2,
    REQ_DEL     = 2'd3
  } req_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_IDLE    = 2'd1,
    ST_NOT_IN_USE = 2'd2,
    ST_EXHAUSTED  = 2'd3
  } status_e_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [SLOT_W-1:0] slot;
    logic [AMT_W-1:0]  amount;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    granted_slot;
    logic                 fresh_buffer;
    logic                 retired;
    logic [AMT_W-1:0]     done_count;
    logic [CNT_OUT_W-1:0] capacity;
    logic [CNT_OUT_W-1:0] used;
    logic [CNT_OUT_W-1:0] available;
    logic [CNT_OUT_W-1:0] allocated;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic wp_inc;
    logic capture;
    logic mark_miss;
    logic add_step;
    logic del_cap;
    logic del_step;
    logic commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             word_hit;
    logic             wp_last;
    logic             rem_zero;
    logic             fresh_room;
  } sts_t;

endpackage

>>> rtl/bspa_stream_if.sv
// Valid/ready stream channel with a typed payload.
// No dependencies.
interface bspa_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/bspa_dp.sv
// Datapath: slot bitmaps, counters, word scan and result register.
// Depends on bspa_pkg.
module bspa_dp import bspa_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item_data,
  input  cmd_t    cmd,
  output sts_t    sts,
  output result_t res
);

  localparam int CW    = (NUM_SLOTS < CHUNK_MAX) ? NUM_SLOTS : CHUNK_MAX;
  localparam int NW    = (NUM_SLOTS + CW - 1) / CW;
  localparam int PW    = NW * CW;
  localparam int PIW   = $clog2(PW);
  localparam int PSW   = $clog2(CW);
  localparam int WPW   = (NW > 1) ? $clog2(NW) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int EW    = ((PIW > SLOT_W) ? PIW : SLOT_W) + 1;
  localparam int DW    = (CNT_W > AMT_W) ? CNT_W : AMT_W;

  // maps are padded to whole words; pad bits are never set
  logic [PW-1:0]     idle_map, idle_map_next;
  logic [PW-1:0]     in_use_map, in_use_map_next;
  logic [PW-1:0]     backed_map, backed_map_next;
  logic [CNT_W-1:0]  next_fresh, next_fresh_next;
  logic [CNT_W-1:0]  cap, cap_next;
  logic [CNT_W-1:0]  used, used_next;
  logic [CNT_W-1:0]  avail, avail_next;
  logic [CNT_W-1:0]  alloc, alloc_next;

  logic [REQ_W-1:0]  op, op_next;
  logic [SLOT_W-1:0] slot_r, slot_r_next;
  logic [AMT_W-1:0]  rem, rem_next;
  logic [AMT_W-1:0]  done, done_next;
  logic              miss, miss_next;
  logic [WPW-1:0]    wp, wp_next;
  logic [PIW-1:0]    found, found_next;
  result_t           res_next;

  logic [CW-1:0]     word;
  logic [CW-1:0]     bword;
  logic [CW-1:0]     oh;
  logic [PSW-1:0]    pos;
  logic [EW-1:0]     slot_ext;
  logic              rel_ok;

  assign word     = idle_map[int'(wp)*CW +: CW];
  assign bword    = backed_map[int'(wp)*CW +: CW];
  assign oh       = word & (~word + CW'(1));
  assign slot_ext = EW'(slot_r);
  assign rel_ok   = (slot_ext < EW'(NUM_SLOTS)) && in_use_map[slot_ext[PIW-1:0]];

  always_comb begin
    pos = '0;
    for (int i = 0; i < CW; i++) begin
      if (oh[i]) begin
        pos = pos | PSW'(i);
      end
    end
  end

  assign sts.req_type   = item_data.req_type;
  assign sts.word_hit   = |word;
  assign sts.wp_last    = (wp == WPW'(NW - 1));
  assign sts.rem_zero   = (rem == '0);
  assign sts.fresh_room = (next_fresh < CNT_W'(NUM_SLOTS));

  always_comb begin
    logic [DW-1:0] cap_w;
    logic [DW-1:0] amt_w;
    cap_w           = DW'(cap);
    amt_w           = DW'(rem);
    idle_map_next   = idle_map;
    in_use_map_next = in_use_map;
    backed_map_next = backed_map;
    next_fresh_next = next_fresh;
    cap_next        = cap;
    used_next       = used;
    avail_next      = avail;
    alloc_next      = alloc;
    op_next         = op;
    slot_r_next     = slot_r;
    rem_next        = rem;
    done_next       = done;
    miss_next       = miss;
    wp_next         = wp;
    found_next      = found;
    res_next        = res;

    if (cmd.load) begin
      op_next     = item_data.req_type;
      slot_r_next = item_data.slot;
      rem_next    = item_data.amount;
      done_next   = '0;
      miss_next   = 1'b0;
      wp_next     = '0;
    end
    if (cmd.wp_inc) begin
      wp_next = wp + WPW'(1);
    end
    if (cmd.capture) begin
      found_next = PIW'(int'(wp) * CW + int'(pos));
    end
    if (cmd.mark_miss) begin
      miss_next = 1'b1;
    end
    if (cmd.add_step) begin
      idle_map_next[PIW'(next_fresh)] = 1'b1;
      avail_next      = avail + CNT_W'(1);
      cap_next        = cap + CNT_W'(1);
      next_fresh_next = next_fresh + CNT_W'(1);
      done_next       = done + AMT_W'(1);
      rem_next        = rem - AMT_W'(1);
    end
    if (cmd.del_cap) begin
      cap_next = (amt_w > cap_w) ? '0 : CNT_W'(cap_w - amt_w);
    end
    if (cmd.del_step) begin
      idle_map_next[int'(wp)*CW +: CW] = word & ~oh;
      if (|(bword & oh)) begin
        backed_map_next[int'(wp)*CW +: CW] = bword & ~oh;
        alloc_next = alloc - CNT_W'(1);
      end
      avail_next = avail - CNT_W'(1);
      done_next  = done + AMT_W'(1);
      rem_next   = rem - AMT_W'(1);
    end

    if (cmd.commit) begin
      res_next.status       = ST_OK;
      res_next.granted_slot = '0;
      res_next.fresh_buffer = 1'b0;
      res_next.retired      = 1'b0;
      res_next.done_count   = '0;
      case (op)
        REQ_ALLOC: begin
          if (miss) begin
            res_next.status = ST_NO_IDLE;
          end else begin
            idle_map_next[found]   = 1'b0;
            in_use_map_next[found] = 1'b1;
            avail_next = avail - CNT_W'(1);
            used_next  = used + CNT_W'(1);
            if (!backed_map[found]) begin
              backed_map_next[found] = 1'b1;
              alloc_next = alloc + CNT_W'(1);
              res_next.fresh_buffer = 1'b1;
            end
            res_next.granted_slot = SLOT_W'(found);
          end
        end
        REQ_RELEASE: begin
          if (!rel_ok) begin
            res_next.status = ST_NOT_IN_USE;
          end else begin
            in_use_map_next[slot_ext[PIW-1:0]] = 1'b0;
            used_next = used - CNT_W'(1);
            if (alloc > cap) begin
              backed_map_next[slot_ext[PIW-1:0]] = 1'b0;
              alloc_next = alloc - CNT_W'(1);
              res_next.retired = 1'b1;
            end else begin
              idle_map_next[slot_ext[PIW-1:0]] = 1'b1;
              avail_next = avail + CNT_W'(1);
            end
          end
        end
        REQ_ADD: begin
          res_next.status     = (rem != '0) ? ST_EXHAUSTED : ST_OK;
          res_next.done_count = done;
        end
        default: begin
          res_next.done_count = done;
        end
      endcase
      res_next.capacity  = CNT_OUT_W'(cap_next);
      res_next.used      = CNT_OUT_W'(used_next);
      res_next.available = CNT_OUT_W'(avail_next);
      res_next.allocated = CNT_OUT_W'(alloc_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_map   <= '0;
      in_use_map <= '0;
      backed_map <= '0;
      next_fresh <= '0;
      cap        <= '0;
      used       <= '0;
      avail      <= '0;
      alloc      <= '0;
      op         <= REQ_ALLOC;
      rem        <= '0;
      done       <= '0;
      miss       <= 1'b0;
      wp         <= '0;
    end else begin
      idle_map   <= idle_map_next;
      in_use_map <= in_use_map_next;
      backed_map <= backed_map_next;
      next_fresh <= next_fresh_next;
      cap        <= cap_next;
      used       <= used_next;
      avail      <= avail_next;
      alloc      <= alloc_next;
      op         <= op_next;
      rem        <= rem_next;
      done       <= done_next;
      miss       <= miss_next;
      wp         <= wp_next;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_r_next;
    found  <= found_next;
    res    <= res_next;
  end

endmodule

>>> rtl/bspa_ctrl.sv
// Controller FSM: sequences scan, capacity loops and result commit.
// Depends on bspa_pkg and buffer_slot_pool_allocator_unit_assert.svh.
`include "buffer_slot_pool_allocator_unit_assert.svh"

module bspa_ctrl import bspa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_ADD    = 6'b000100,
    S_DELCAP = 6'b001000,
    S_DEL    = 6'b010000,
    S_COMMIT = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (sts.req_type)
            REQ_ALLOC:   state_next = S_SCAN;
            REQ_RELEASE: state_next = S_COMMIT;
            REQ_ADD:     state_next = S_ADD;
            default:     state_next = S_DELCAP;
          endcase
        end
      end
      S_SCAN: begin
        if (sts.word_hit) begin
          cmd.capture = 1'b1;
          state_next  = S_COMMIT;
        end else if (sts.wp_last) begin
          cmd.mark_miss = 1'b1;
          state_next    = S_COMMIT;
        end else begin
          cmd.wp_inc = 1'b1;
        end
      end
      S_ADD: begin
        if (!sts.rem_zero && sts.fresh_room) begin
          cmd.add_step = 1'b1;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_DELCAP: begin
        cmd.del_cap = 1'b1;
        state_next  = S_DEL;
      end
      S_DEL: begin
        if (sts.rem_zero) begin
          state_next = S_COMMIT;
        end else if (sts.word_hit) begin
          cmd.del_step = 1'b1;
        end else if (sts.wp_last) begin
          state_next = S_COMMIT;
        end else begin
          cmd.wp_inc = 1'b1;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `BSPA_ASSERT_IMP(a_commit_free, cmd.commit, out_free, "commit with result register full")
  `BSPA_ASSERT_NXT(a_commit_shows, cmd.commit, out_valid, "committed result not presented")
  `BSPA_ASSERT_NXT(a_accept_busy, in_valid && in_ready, state != S_IDLE, "accept did not start work")
  `BSPA_ASSERT_IMP(a_wp_bound, cmd.wp_inc, !sts.wp_last, "word pointer stepped past last word")

endmodule

>>> rtl/buffer_slot_pool_allocator_unit.sv
// Top level of the slot pool allocator: controller plus datapath.
// Depends on bspa_pkg, bspa_stream_if, bspa_ctrl and bspa_dp.
//
//  channel  dir  payload   transaction
//  item     in   item_t    one request, release or capacity change
//  result   out  result_t  one result per item, in order
//
// A release commits directly, a request scans the idle map, an add places new slots,
// a remove drops capacity and idle slots; the scan walks 64 bitmap bits per cycle.
// A new item is taken once the previous result is in the output register.
// Synchronous reset empties all maps and counters.
// A stalled result holds off the commit of the item behind it, and so further intake.
module buffer_slot_pool_allocator_unit import bspa_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  bspa_stream_if.sink   item,
  bspa_stream_if.source result
);

  cmd_t    cmd;
  sts_t    sts;
  item_t   item_data;
  result_t res;
  logic    in_ready;
  logic    out_valid;

  assign item_data   = item.data;
  assign item.ready  = in_ready;
  assign result.valid = out_valid;
  assign result.data  = res;

  bspa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bspa_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item_data (item_data),
    .cmd       (cmd),
    .sts       (sts),
    .res       (res)
  );

endmodule

>>> tb/tb_buffer_slot_pool_allocator_unit.sv
// Self-checking testbench for buffer_slot_pool_allocator_unit: directed, back-pressure,
// random and exhaustion tests, with an in-order scoreboard fed by a slot pool predictor.
// Depends on bspa_pkg, bspa_stream_if and the allocator RTL.
module tb_buffer_slot_pool_allocator_unit;
  import bspa_pkg::*;

  localparam int NSLOTS = NUM_SLOTS_DEF;
  localparam int FRESH_RESERVE = NSLOTS - 6;
  localparam int DRAIN_CYCLES = 150;

  logic clk;
  logic rst = 1'b1;

  bspa_stream_if #(.T(item_t))   item_ch ();
  bspa_stream_if #(.T(result_t)) result_ch ();

  buffer_slot_pool_allocator_unit #(.NUM_SLOTS(NSLOTS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // predictor state
  logic [NSLOTS-1:0] idle_bits;
  logic [NSLOTS-1:0] busy_bits;
  logic [NSLOTS-1:0] backed_bits;
  int fresh_next, cap_cnt, used_cnt, avail_cnt, alloc_cnt;

  result_t pending_results[$];

  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;
  int hold_request = 0;
  int holds_done = 0;
  int mismatches = 0;
  int op_tally[4] = '{default: 0};
  int status_tally[4] = '{default: 0};
  int fresh_grants = 0;
  int retirements = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int lowest_idle();
    for (int i = 0; i < NSLOTS; i++) if (idle_bits[i]) return i;
    return NSLOTS;
  endfunction

  function automatic result_t pool_apply(input item_t it);
    result_t r;
    int s;
    int room;
    int done;
    r = '0;
    done = 0;
    case (it.req_type)
      REQ_ALLOC: begin
        s = lowest_idle();
        if (s >= NSLOTS) begin
          r.status = ST_NO_IDLE;
        end else begin
          idle_bits[s] = 1'b0;
          avail_cnt--;
          busy_bits[s] = 1'b1;
          used_cnt++;
          if (!backed_bits[s]) begin
            backed_bits[s] = 1'b1;
            alloc_cnt++;
            r.fresh_buffer = 1'b1;
          end
          r.granted_slot = SLOT_W'(s);
        end
      end
      REQ_RELEASE: begin
        if (!busy_bits[it.slot]) begin
          r.status = ST_NOT_IN_USE;
        end else begin
          busy_bits[it.slot] = 1'b0;
          used_cnt--;
          if (alloc_cnt > cap_cnt) begin
            backed_bits[it.slot] = 1'b0;
            alloc_cnt--;
            r.retired = 1'b1;
          end else begin
            idle_bits[it.slot] = 1'b1;
            avail_cnt++;
          end
        end
      end
      REQ_ADD: begin
        room = NSLOTS - fresh_next;
        done = (int'(it.amount) < room) ? int'(it.amount) : room;
        for (int k = 0; k < done; k++) begin
          idle_bits[fresh_next] = 1'b1;
          avail_cnt++;
          fresh_next++;
        end
        cap_cnt += done;
        if (done < int'(it.amount)) r.status = ST_EXHAUSTED;
      end
      default: begin
        cap_cnt = (int'(it.amount) > cap_cnt) ? 0 : cap_cnt - int'(it.amount);
        for (int k = 0; k < int'(it.amount); k++) begin
          s = lowest_idle();
          if (s >= NSLOTS) break;
          idle_bits[s] = 1'b0;
          avail_cnt--;
          if (backed_bits[s]) begin
            backed_bits[s] = 1'b0;
            alloc_cnt--;
          end
          done++;
        end
      end
    endcase
    r.done_count = AMT_W'(done);
    r.capacity   = CNT_OUT_W'(cap_cnt);
    r.used       = CNT_OUT_W'(used_cnt);
    r.available  = CNT_OUT_W'(avail_cnt);
    r.allocated  = CNT_OUT_W'(alloc_cnt);
    return r;
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf({"st=%0d slot=%0d fresh=%0d ret=%0d done=%0d ",
                      "cap=%0d used=%0d avail=%0d alloc=%0d"},
                     r.status, r.granted_slot, r.fresh_buffer, r.retired, r.done_count,
                     r.capacity, r.used, r.available, r.allocated);
  endfunction

  task automatic check_result(input result_t got);
    result_t want;
    bit bad;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected result transaction: %s", fmt_result(got));
      return;
    end
    want = pending_results.pop_front();
    bad = (got.status != want.status) || (got.granted_slot != want.granted_slot) ||
          (got.fresh_buffer != want.fresh_buffer) || (got.retired != want.retired) ||
          (got.done_count != want.done_count) || (got.capacity != want.capacity) ||
          (got.used != want.used) || (got.available != want.available) ||
          (got.allocated != want.allocated);
    status_tally[want.status]++;
    fresh_grants += want.fresh_buffer;
    retirements += want.retired;
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: result mismatch at %0t", $time);
        $display("  expected %s", fmt_result(want));
        $display("  actual   %s", fmt_result(got));
      end
    end
  endtask

  initial begin : result_checker
    int stall;
    result_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
        holds_done++;
      end else begin
        stall = rx_stalls_on ? $urandom_range(0, 10) : 0;
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      check_result(result_ch.data);
    end
  end

  task automatic send_item(input item_t it);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    pending_results.push_back(pool_apply(it));
    op_tally[it.req_type]++;
  endtask

  task automatic send_op(input req_e_t op, input int slot_no, input int amt);
    item_t it;
    it.req_type = op;
    it.slot = SLOT_W'(slot_no);
    it.amount = AMT_W'(amt);
    send_item(it);
  endtask

  task automatic test_directed();
    send_op(REQ_ALLOC, 63, 64);
    send_op(REQ_RELEASE, 0, 0);
    send_op(REQ_RELEASE, 63, 64);
    send_op(REQ_ADD, 21, 0);
    send_op(REQ_DEL, 42, 0);
    send_op(REQ_DEL, 7, 5);
    send_op(REQ_ADD, 0, 4);
    repeat (3) send_op(REQ_ALLOC, $urandom_range(0, 63), $urandom_range(0, 64));
    send_op(REQ_RELEASE, 1, 0);
    send_op(REQ_ALLOC, 0, 0);
    send_op(REQ_DEL, 0, 3);
    send_op(REQ_RELEASE, 2, 0);
    send_op(REQ_RELEASE, 2, 0);
    send_op(REQ_ADD, 0, 2);
    send_op(REQ_ALLOC, 0, 0);
  endtask

  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    hold_request = 300;
    for (int i = 0; i < 16; i++) begin
      send_op((i % 2 == 0) ? REQ_ALLOC : REQ_RELEASE, $urandom_range(0, 7),
              $urandom_range(0, 64));
    end
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int n_items);
    item_t it;
    int roll;
    int room;
    int busy_list[$];
    for (int i = 0; i < n_items; i++) begin
      if (i % 200 == 0) begin
        tx_gaps_on = ((i / 200) % 3 != 1);
        rx_stalls_on = ((i / 200) % 3 != 2);
      end
      roll = $urandom_range(0, 99);
      it.slot = SLOT_W'($urandom_range(0, 63));
      it.amount = AMT_W'($urandom_range(0, 64));
      room = FRESH_RESERVE - fresh_next;
      if (roll < 5 || (avail_cnt == 0 && roll < 30)) begin
        it.req_type = REQ_ADD;
        it.amount = (room > 0) ? AMT_W'($urandom_range(0, (room < 3) ? room : 3)) : '0;
      end else if (roll < 9) begin
        it.req_type = REQ_DEL;
        it.amount = AMT_W'($urandom_range(0, 3));
      end else if (roll < 54 || busy_bits == '0) begin
        it.req_type = REQ_ALLOC;
      end else begin
        it.req_type = REQ_RELEASE;
        if ($urandom_range(0, 9) != 0) begin
          busy_list.delete();
          for (int k = 0; k < NSLOTS; k++) if (busy_bits[k]) busy_list.push_back(k);
          it.slot = SLOT_W'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
        end
      end
      send_item(it);
    end
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  task automatic test_exhaustion();
    send_op(REQ_ADD, 0, 64);
    send_op(REQ_ADD, 63, 64);
    repeat (3) send_op(REQ_ALLOC, $urandom_range(0, 63), $urandom_range(0, 64));
    send_op(REQ_DEL, 0, 64);
    send_op(REQ_ALLOC, 0, 0);
    for (int k = 0; k < NSLOTS; k++) if (busy_bits[k]) send_op(REQ_RELEASE, k, 0);
    send_op(REQ_ALLOC, 0, 0);
    send_op(REQ_ADD, 0, 1);
  endtask

  initial begin
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    idle_bits = '0;
    busy_bits = '0;
    backed_bits = '0;
    fresh_next = 0;
    cap_cnt = 0;
    used_cnt = 0;
    avail_cnt = 0;
    alloc_cnt = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random_traffic(1360);
    test_exhaustion();

    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display({"Covered %0d request, %0d release, %0d add and %0d remove transactions, ",
              "%0d long holds."},
             op_tally[REQ_ALLOC], op_tally[REQ_RELEASE], op_tally[REQ_ADD], op_tally[REQ_DEL],
             holds_done);
    $display({"Saw %0d fresh grants, %0d retirements, %0d no-idle, %0d not-in-use, ",
              "%0d exhausted."},
             fresh_grants, retirements, status_tally[ST_NO_IDLE], status_tally[ST_NOT_IN_USE],
             status_tally[ST_EXHAUSTED]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/bspa_pkg.sv
rtl/bspa_stream_if.sv
rtl/bspa_dp.sv
rtl/bspa_ctrl.sv
rtl/buffer_slot_pool_allocator_unit.sv
tb/tb_buffer_slot_pool_allocator_unit.sv
